// ----- rtl/sal_pkg.sv -----
// ----------------------------------------------------------------------------
// sal_pkg
// Shared constants, codes and types for the shifting array list.
// ----------------------------------------------------------------------------
package sal_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int REQ_W    = 3;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int STAT_W   = 2;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ      = 3'd2;
    localparam logic [REQ_W-1:0] REQ_OVERWRITE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_APPEND    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd5;

    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_OOB     = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd3;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } sal_wr_t;

endpackage

// ----- rtl/sal_store.sv -----
// ----------------------------------------------------------------------------
// sal_store
// Entry store: one write port, one combinational read port, cleared at reset.
// ----------------------------------------------------------------------------
module sal_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sal_pkg::sal_wr_t              wr,
    input  logic [sal_pkg::IDX_W-1:0]     raddr,
    output logic [sal_pkg::DATA_W-1:0]    rdata
);
    import sal_pkg::*;

    logic [DATA_W-1:0] entry_reg [CAPACITY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            entry_reg[wr.addr] <= wr.data;
        end
    end

    assign rdata = entry_reg[raddr];

endmodule

// ----- rtl/shifting_array_list.sv -----
// ----------------------------------------------------------------------------
// shifting_array_list
// Ordered list of signed 32-bit words with insert, remove, read, overwrite,
// append and clear, built on a one-entry-per-cycle shift sequencer.
//
// Usage:
//   Raise start with req_type, position and data_value while busy is low;
//   the word is taken at that edge and busy rises the next cycle.
//   One entry moves per cycle through the single store port. An insert
//   shifts the entries from position to the end up by one slot, last entry
//   first, then writes the new word at position and raises the count; a
//   remove shifts the entries after position down by one slot, then zeroes
//   the old last entry and lowers the count; clear zeroes each entry in turn,
//   then sets the count to zero; other and failed requests do no shifting.
//   done pulses for one cycle right after the sequencer ends, carrying status,
//   read_value and list_count; busy is already low then, so the next word may
//   be taken in that cycle. No new word is taken while busy is high.
//   The receiver cannot stall: each result is valid only while done is high.
//   Reset clears the store to zeros, the count to zero, and returns idle.
// ----------------------------------------------------------------------------
module shifting_array_list (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [sal_pkg::REQ_W-1:0]          req_type,
    input  logic [sal_pkg::POS_W-1:0]          position,
    input  logic signed [sal_pkg::DATA_W-1:0]  data_value,
    output logic                               done,
    output logic [sal_pkg::STAT_W-1:0]         status,
    output logic signed [sal_pkg::DATA_W-1:0]  read_value,
    output logic [sal_pkg::COUNT_W-1:0]        list_count
);
    import sal_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [REQ_W-1:0]   req_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [DATA_W-1:0]  val_reg;
    logic [STAT_W-1:0]  stat_reg, stat_next;
    logic [CNT_W-1:0]   cur_reg, cur_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               done_reg;
    logic [DATA_W-1:0]  rdout_reg, rdout_next;
    logic [STAT_W-1:0]  stout_reg;

    logic               accept;
    logic               finish;
    logic               pos_bad;
    logic [IDX_W-1:0]   idx_in;
    logic [CNT_W-1:0]   cur_init;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [IDX_W-1:0]   raddr;
    logic [DATA_W-1:0]  rdata;
    sal_wr_t            wr;

    sal_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign accept  = start && (state_reg == ST_IDLE);
    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_bad = (position == '0) || (pos_ext > CMP_W'(CAPACITY));
    assign idx_in  = pos_bad ? '0 : IDX_W'(position - POS_W'(1));

    // decode the request at acceptance
    always_comb
    begin
        stat_next = STATUS_OK;
        cur_init  = '0;
        case (req_type)
            REQ_INSERT:
            begin
                if (pos_bad)
                    stat_next = STATUS_OOB;
                else if (pos_ext > cnt_ext + CMP_W'(1))
                    stat_next = STATUS_INVALID;
                else if (cnt_ext >= CMP_W'(CAPACITY))
                    stat_next = STATUS_FULL;
                cur_init = count_reg;
            end
            REQ_REMOVE:
            begin
                if (pos_bad)
                    stat_next = STATUS_OOB;
                else if (pos_ext > cnt_ext)
                    stat_next = STATUS_INVALID;
                cur_init = CNT_W'(idx_in);
            end
            REQ_READ, REQ_OVERWRITE:
            begin
                if (pos_bad)
                    stat_next = STATUS_OOB;
            end
            REQ_APPEND:
            begin
                if (cnt_ext >= CMP_W'(CAPACITY))
                    stat_next = STATUS_FULL;
            end
            default:
            begin
                stat_next = STATUS_OK;
            end
        endcase
    end

    // one store move per cycle
    always_comb
    begin
        wr         = '0;
        raddr      = idx_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        rdout_next = '0;
        finish     = 1'b0;
        if (state_reg == ST_RUN)
        begin
            if (stat_reg != STATUS_OK)
            begin
                finish = 1'b1;
            end
            else
            begin
                case (req_reg)
                    REQ_INSERT:
                    begin
                        if (cur_reg > CNT_W'(idx_reg))
                        begin
                            raddr    = IDX_W'(cur_reg - CNT_W'(1));
                            wr.en    = 1'b1;
                            wr.addr  = IDX_W'(cur_reg);
                            wr.data  = rdata;
                            cur_next = cur_reg - CNT_W'(1);
                        end
                        else
                        begin
                            wr.en      = 1'b1;
                            wr.addr    = idx_reg;
                            wr.data    = val_reg;
                            count_next = count_reg + CNT_W'(1);
                            finish     = 1'b1;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (CMP_W'(cur_reg) + CMP_W'(1) < CMP_W'(count_reg))
                        begin
                            raddr    = IDX_W'(cur_reg + CNT_W'(1));
                            wr.en    = 1'b1;
                            wr.addr  = IDX_W'(cur_reg);
                            wr.data  = rdata;
                            cur_next = cur_reg + CNT_W'(1);
                        end
                        else
                        begin
                            wr.en      = 1'b1;
                            wr.addr    = IDX_W'(count_reg - CNT_W'(1));
                            wr.data    = '0;
                            count_next = count_reg - CNT_W'(1);
                            finish     = 1'b1;
                        end
                    end
                    REQ_READ:
                    begin
                        rdout_next = rdata;
                        finish     = 1'b1;
                    end
                    REQ_OVERWRITE:
                    begin
                        wr.en   = 1'b1;
                        wr.addr = idx_reg;
                        wr.data = val_reg;
                        finish  = 1'b1;
                    end
                    REQ_APPEND:
                    begin
                        wr.en      = 1'b1;
                        wr.addr    = IDX_W'(count_reg);
                        wr.data    = val_reg;
                        count_next = count_reg + CNT_W'(1);
                        finish     = 1'b1;
                    end
                    REQ_CLEAR:
                    begin
                        if (cur_reg < count_reg)
                        begin
                            wr.en    = 1'b1;
                            wr.addr  = IDX_W'(cur_reg);
                            wr.data  = '0;
                            cur_next = cur_reg + CNT_W'(1);
                        end
                        else
                        begin
                            count_next = '0;
                            finish     = 1'b1;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (finish)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            idx_reg  <= idx_in;
            val_reg  <= data_value;
            stat_reg <= stat_next;
            cur_reg  <= cur_init;
        end
        else
        begin
            cur_reg <= cur_next;
        end
        if (finish)
        begin
            rdout_reg <= rdout_next;
            stout_reg <= stat_reg;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign status     = stout_reg;
    assign read_value = rdout_reg;
    assign list_count = COUNT_W'(count_reg);

endmodule

// ----- rtl/sal_checker.sv -----
// ----------------------------------------------------------------------------
// sal_checker
// Port-level checks on the request/done sequencing and the reported count of the shifting array list.
// ----------------------------------------------------------------------------
module sal_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          done,
    input  logic [sal_pkg::STAT_W-1:0]    status,
    input  logic [sal_pkg::COUNT_W-1:0]   list_count
);
    import sal_pkg::*;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not start the sequencer");

    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> (list_count == $past(list_count)))
        else $error("failed request changed the count");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (int'(list_count) <= CAPACITY))
        else $error("count beyond capacity");

endmodule

bind shifting_array_list sal_checker u_sal_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .list_count (list_count)
);

// ----- tb/tb_shifting_array_list.sv -----
// ----------------------------------------------------------------------------
// tb_shifting_array_list
// Drives random and directed list requests through the start/busy port and
// checks each done reply against a shadow copy of the list kept in the bench.
// ----------------------------------------------------------------------------
module tb_shifting_array_list;

    import sal_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 750;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       count;
    } list_reply_t;

    class list_shadow;
        logic signed [DATA_W-1:0] slots [CAPACITY];
        int unsigned count;
        list_reply_t pending [$];
        int unsigned checked;
        int unsigned mismatches;
        int unsigned error_replies;
        int unsigned full_hits;

        function new();
            foreach (slots[i])
                slots[i] = '0;
            count = 0;
            checked = 0;
            mismatches = 0;
            error_replies = 0;
            full_hits = 0;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                                   logic signed [DATA_W-1:0] val);
            list_reply_t r;
            bit pos_bad;
            int idx;
            r.status = STATUS_OK;
            r.value = '0;
            pos_bad = (pos == 0) || (pos > CAPACITY);
            idx = pos_bad ? 0 : int'(pos) - 1;
            case (req)
                REQ_INSERT:
                begin
                    if (pos_bad)
                        r.status = STATUS_OOB;
                    else if (pos > count + 1)
                        r.status = STATUS_INVALID;
                    else if (count >= CAPACITY)
                        r.status = STATUS_FULL;
                    else
                    begin
                        for (int i = count; i > idx; i--)
                            slots[i] = slots[i-1];
                        slots[idx] = val;
                        count++;
                    end
                end
                REQ_REMOVE:
                begin
                    if (pos_bad)
                        r.status = STATUS_OOB;
                    else if (pos > count)
                        r.status = STATUS_INVALID;
                    else
                    begin
                        for (int i = idx; i + 1 < count; i++)
                            slots[i] = slots[i+1];
                        slots[count-1] = '0;
                        count--;
                    end
                end
                REQ_READ:
                begin
                    if (pos_bad)
                        r.status = STATUS_OOB;
                    else
                        r.value = slots[idx];
                end
                REQ_OVERWRITE:
                begin
                    if (pos_bad)
                        r.status = STATUS_OOB;
                    else
                        slots[idx] = val;
                end
                REQ_APPEND:
                begin
                    if (count >= CAPACITY)
                        r.status = STATUS_FULL;
                    else
                    begin
                        slots[count] = val;
                        count++;
                    end
                end
                REQ_CLEAR:
                begin
                    for (int i = 0; i < count; i++)
                        slots[i] = '0;
                    count = 0;
                end
                default:
                begin
                end
            endcase
            r.count = COUNT_W'(count);
            if (r.status != STATUS_OK)
                error_replies++;
            if (r.status == STATUS_FULL)
                full_hits++;
            pending.push_back(r);
        endfunction

        function void check_reply(logic [STAT_W-1:0] status, logic signed [DATA_W-1:0] value,
                                  logic [COUNT_W-1:0] cnt);
            list_reply_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: status %0d value %0d count %0d",
                             status, value, cnt);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (status !== e.status || value !== e.value || cnt !== e.count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                             e.status, e.value, e.count, status, value, cnt);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [REQ_W-1:0]          req_type = REQ_READ;
    logic [POS_W-1:0]          position = '0;
    logic signed [DATA_W-1:0]  data_value = '0;
    logic                      busy;
    logic                      done;
    logic [STAT_W-1:0]         status;
    logic signed [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0]        list_count;

    list_shadow shadow = new();
    int unsigned words_sent = 0;

    shifting_array_list dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .position   (position),
        .data_value (data_value),
        .done       (done),
        .status     (status),
        .read_value (read_value),
        .list_count (list_count)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.check_reply(status, read_value, list_count);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout with %0d replies outstanding", shadow.pending.size());
        $display("tb: failure");
        $finish;
    end

    task automatic send_word(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                             input logic signed [DATA_W-1:0] val);
        @(negedge clk);
        start <= 1'b1;
        req_type <= req;
        position <= pos;
        data_value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shadow.note_request(req, pos, val);
        words_sent++;
    endtask

    task automatic idle_for(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic pick_word(input int mode, output logic [REQ_W-1:0] req,
                             output logic [POS_W-1:0] pos, output logic signed [DATA_W-1:0] val);
        int n;
        int roll;
        int hi;
        n = shadow.count;
        roll = $urandom_range(0, 99);
        case (mode)
            0:
                req = (roll < 45) ? REQ_INSERT : (roll < 75) ? REQ_APPEND :
                      (roll < 85) ? REQ_READ : (roll < 92) ? REQ_OVERWRITE :
                      (roll < 96) ? REQ_REMOVE : (roll < 97) ? REQ_CLEAR :
                      REQ_W'($urandom_range(6, 7));
            1:
                req = (roll < 60) ? REQ_REMOVE : (roll < 75) ? REQ_READ :
                      (roll < 85) ? REQ_OVERWRITE : (roll < 93) ? REQ_INSERT :
                      (roll < 96) ? REQ_CLEAR : REQ_W'($urandom_range(6, 7));
            default:
                req = (roll < 4) ? REQ_CLEAR : REQ_W'($urandom_range(0, 7));
        endcase
        if (req == REQ_INSERT)
            hi = (n + 1 > CAPACITY) ? CAPACITY : n + 1;
        else if (req == REQ_REMOVE)
            hi = (n == 0) ? 1 : n;
        else
            hi = CAPACITY;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            pos = POS_W'($urandom_range(1, hi));
        else if (roll < 90)
        begin
            case ($urandom_range(0, 5))
                0: pos = '0;
                1: pos = POS_W'(n);
                2: pos = POS_W'(n + 1);
                3: pos = POS_W'(n + 2);
                4: pos = POS_W'(CAPACITY);
                default: pos = POS_W'(CAPACITY + 1);
            endcase
        end
        else
            pos = POS_W'($urandom_range(0, 31));
        case ($urandom_range(0, 19))
            0: val = 32'sh7fffffff;
            1: val = 32'sh80000000;
            2: val = '0;
            3: val = -32'sd1;
            default: val = $urandom;
        endcase
    endtask

    initial
    begin
        logic [REQ_W-1:0]         req;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        int random_sent;
        int burst_left;
        int mode_left;
        int mode;
        random_sent = 0;
        burst_left = 0;
        mode_left = 0;
        mode = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(REQ_READ, 5'd1, 32'sd0);
        send_word(REQ_INSERT, 5'd0, 32'sd5);
        send_word(REQ_INSERT, 5'd31, 32'sd5);
        send_word(REQ_REMOVE, 5'd17, 32'sd0);
        send_word(REQ_READ, 5'd0, 32'sd0);
        send_word(REQ_OVERWRITE, 5'd0, 32'sd9);
        send_word(REQ_INSERT, 5'd2, 32'sd7);
        send_word(REQ_REMOVE, 5'd1, 32'sd0);
        send_word(REQ_INSERT, 5'd1, 32'sh7fffffff);
        send_word(REQ_INSERT, 5'd1, 32'sh80000000);
        send_word(REQ_APPEND, 5'd31, -32'sd1);
        send_word(REQ_INSERT, 5'd2, 32'sh5a5a5a5a);
        send_word(REQ_OVERWRITE, 5'd16, 32'sh12345678);
        send_word(REQ_READ, 5'd16, 32'sd0);
        send_word(REQ_READ, 5'd4, 32'sd0);
        send_word(REQ_REMOVE, 5'd4, 32'sd0);
        send_word(REQ_REMOVE, 5'd1, 32'sd0);
        send_word(REQ_W'(6), 5'd1, 32'sd3);
        send_word(REQ_W'(7), 5'd2, 32'sd3);
        send_word(REQ_CLEAR, 5'd9, 32'sd0);
        send_word(REQ_READ, 5'd16, 32'sd0);
        send_word(REQ_READ, 5'd1, 32'sd0);

        while (random_sent < RANDOM_WORDS)
        begin
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 60);
            end
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    idle_for($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 4));
                burst_left = $urandom_range(1, 24);
            end
            pick_word(mode, req, pos, val);
            send_word(req, pos, val);
            burst_left--;
            mode_left--;
            random_sent++;
        end
        @(negedge clk);
        start <= 1'b0;

        while (shadow.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d words, checked %0d replies, %0d mismatches",
                 words_sent, shadow.checked, shadow.mismatches);
        $display("%0d replies carried an error status, %0d of them on a full list",
                 shadow.error_replies, shadow.full_hits);
        if (shadow.mismatches == 0 && shadow.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sal_pkg.sv
rtl/sal_store.sv
rtl/shifting_array_list.sv
rtl/sal_checker.sv
tb/tb_shifting_array_list.sv
